// ----- hw/rtl/fte_pkg.sv -----
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types, codes and the control store of the fenwick tree engine.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int IDX_W  = 11;
  localparam int OUT_W  = 32;
  localparam int FUNC_W = 2;
  localparam int UPC_W  = 4;

  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_PREFIX = 2'd1,
    FUNC_RANGE  = 2'd2,
    FUNC_SELECT = 2'd3
  } func_t;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_LOAD_P     = 4'd1,
    OP_LOAD_R     = 4'd2,
    OP_SAVE_LO    = 4'd3,
    OP_PWALK      = 4'd4,
    OP_LOAD_ADD   = 4'd5,
    OP_AWALK      = 4'd6,
    OP_SINIT      = 4'd7,
    OP_SREAD      = 4'd8,
    OP_SEVAL      = 4'd9,
    OP_EMIT_SUM   = 4'd10,
    OP_EMIT_RANGE = 4'd11,
    OP_EMIT_SEL   = 4'd12
  } op_t;

  // jump condition
  typedef enum logic [1:0] {
    JMP_NEVER     = 2'd0,
    JMP_IDX_NZ    = 2'd1,
    JMP_ADD_MORE  = 2'd2,
    JMP_STEP_MORE = 2'd3
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  emit;
    logic  last;
  } ucode_t;

  typedef struct packed {
    logic idx_nz;
    logic add_more;
    logic step_more;
  } dp_stat_t;

  // program addresses
  localparam upc_t UA_P_LOAD  = 4'd0;
  localparam upc_t UA_P_WALK  = 4'd1;
  localparam upc_t UA_P_RES   = 4'd2;
  localparam upc_t UA_R_LOAD  = 4'd3;
  localparam upc_t UA_R_WALK1 = 4'd4;
  localparam upc_t UA_R_SAVE  = 4'd5;
  localparam upc_t UA_R_WALK2 = 4'd6;
  localparam upc_t UA_R_RES   = 4'd7;
  localparam upc_t UA_A_LOAD  = 4'd8;
  localparam upc_t UA_A_WALK  = 4'd9;
  localparam upc_t UA_S_INIT  = 4'd10;
  localparam upc_t UA_S_READ  = 4'd11;
  localparam upc_t UA_S_EVAL  = 4'd12;
  localparam upc_t UA_S_RES   = 4'd13;

  function automatic ucode_t uc(op_t op, cond_t cond, upc_t target, logic emit,
                                logic last);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.emit   = emit;
    w.last   = last;
    return w;
  endfunction

  localparam ucode_t UC_IDLE = '{op: OP_NOP, cond: JMP_NEVER, target: 4'd0,
                                 emit: 1'b0, last: 1'b1};

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    case (a)
      UA_P_LOAD:  w = uc(OP_LOAD_P,     JMP_NEVER,     UA_P_LOAD,  1'b0, 1'b0);
      UA_P_WALK:  w = uc(OP_PWALK,      JMP_IDX_NZ,    UA_P_WALK,  1'b0, 1'b0);
      UA_P_RES:   w = uc(OP_EMIT_SUM,   JMP_NEVER,     UA_P_LOAD,  1'b1, 1'b1);
      UA_R_LOAD:  w = uc(OP_LOAD_R,     JMP_NEVER,     UA_R_LOAD,  1'b0, 1'b0);
      UA_R_WALK1: w = uc(OP_PWALK,      JMP_IDX_NZ,    UA_R_WALK1, 1'b0, 1'b0);
      UA_R_SAVE:  w = uc(OP_SAVE_LO,    JMP_NEVER,     UA_R_SAVE,  1'b0, 1'b0);
      UA_R_WALK2: w = uc(OP_PWALK,      JMP_IDX_NZ,    UA_R_WALK2, 1'b0, 1'b0);
      UA_R_RES:   w = uc(OP_EMIT_RANGE, JMP_NEVER,     UA_R_LOAD,  1'b1, 1'b1);
      UA_A_LOAD:  w = uc(OP_LOAD_ADD,   JMP_NEVER,     UA_A_LOAD,  1'b0, 1'b0);
      UA_A_WALK:  w = uc(OP_AWALK,      JMP_ADD_MORE,  UA_A_WALK,  1'b0, 1'b1);
      UA_S_INIT:  w = uc(OP_SINIT,      JMP_NEVER,     UA_S_INIT,  1'b0, 1'b0);
      UA_S_READ:  w = uc(OP_SREAD,      JMP_NEVER,     UA_S_READ,  1'b0, 1'b0);
      UA_S_EVAL:  w = uc(OP_SEVAL,      JMP_STEP_MORE, UA_S_READ,  1'b0, 1'b0);
      UA_S_RES:   w = uc(OP_EMIT_SEL,   JMP_NEVER,     UA_S_INIT,  1'b1, 1'b1);
      default:    w = UC_IDLE;
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(func_t f);
    upc_t a;
    case (f)
      FUNC_ADD:    a = UA_A_LOAD;
      FUNC_PREFIX: a = UA_P_LOAD;
      FUNC_RANGE:  a = UA_R_LOAD;
      FUNC_SELECT: a = UA_S_INIT;
      default:     a = UA_P_LOAD;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/fte_useq.sv -----
// ----------------------------------------------------------------------------
// fte_useq
// Step counter over the control store, with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module fte_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fte_pkg::func_t   func,
  input  fte_pkg::dp_stat_t stat,
  input  logic             out_block,
  output fte_pkg::ucode_t  cw,
  output logic             emit_fire,
  output logic             busy
);
  import fte_pkg::*;

  upc_t upc_r, upc_nxt;
  logic busy_r, busy_nxt;
  logic take;
  logic stall;

  always_comb begin
    cw = busy_r ? ucode_rom(upc_r) : UC_IDLE;
    case (cw.cond)
      JMP_NEVER:     take = 1'b0;
      JMP_IDX_NZ:    take = stat.idx_nz;
      JMP_ADD_MORE:  take = stat.add_more;
      JMP_STEP_MORE: take = stat.step_more;
      default:       take = 1'b0;
    endcase
    stall     = cw.emit && out_block;
    emit_fire = cw.emit && !out_block;

    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (start) begin
      upc_nxt  = dispatch(func);
      busy_nxt = 1'b1;
    end else if (busy_r && !stall) begin
      if (take) begin
        upc_nxt = cw.target;
      end else if (cw.last) begin
        busy_nxt = 1'b0;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ----- hw/rtl/fte_dpath.sv -----
// ----------------------------------------------------------------------------
// fte_dpath
// Cell memory, walk index, accumulators and select search registers.
// ----------------------------------------------------------------------------
module fte_dpath #(
  parameter int TABLE_SIZE  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fte_pkg::IDX_W-1:0] size_in_use,
  input  logic [fte_pkg::IDX_W-1:0] left_index,
  input  logic [fte_pkg::IDX_W-1:0] right_index,
  input  logic signed [31:0]        amount,
  input  logic signed [31:0]        rank_target,
  input  fte_pkg::ucode_t           cw,
  output fte_pkg::dp_stat_t         stat,
  output logic                      clr_done,
  output logic [fte_pkg::OUT_W-1:0] res_total,
  output logic [fte_pkg::IDX_W-1:0] res_found
);
  import fte_pkg::*;

  localparam int AW       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int IW       = $clog2(TABLE_SIZE) + 2;
  localparam int XW       = (IW > IDX_W) ? IW : IDX_W;
  localparam int VW       = VALUE_WIDTH;
  localparam int STEP_TOP = 1 << ($clog2(TABLE_SIZE + 1) - 1);

  logic [VW-1:0] mem [TABLE_SIZE];

  logic [IDX_W-1:0] left_r, right_r;
  logic [VW-1:0]    amount_r, target_r;
  logic [IW-1:0]    n_r;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [VW-1:0]    acc_r, acc_nxt, hi_r, hi_nxt, cur_r, cur_nxt;
  logic [IW-1:0]    pos_r, pos_nxt, step_r, step_nxt, cand_r, cand_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    wadr_r, wadr_nxt;
  logic [VW-1:0]    rdata_r;
  logic [AW:0]      clr_cnt_r;

  logic             clr_busy;
  logic             rd_en, we;
  logic [AW-1:0]    raddr, waddr;
  logic [VW-1:0]    wdata;
  logic [IW-1:0]    n_start, left_cl, right_cl, lm1_cl, low, cand;
  logic [IDX_W-1:0] lm1;
  logic             add_ok;
  logic [VW-1:0]    sel_next, diff;
  logic             sel_ge;

  // effective size from the register: zero acts as one, oversize as full
  always_comb begin
    if (size_in_use == '0) begin
      n_start = IW'(1);
    end else if (XW'(size_in_use) > XW'(TABLE_SIZE)) begin
      n_start = IW'(TABLE_SIZE);
    end else begin
      n_start = IW'(size_in_use);
    end
  end

  // query positions clamped to the size
  always_comb begin
    lm1      = (left_r == '0) ? '0 : left_r - 1'b1;
    left_cl  = (XW'(left_r) > XW'(n_r)) ? n_r : IW'(left_r);
    right_cl = (XW'(right_r) > XW'(n_r)) ? n_r : IW'(right_r);
    lm1_cl   = (XW'(lm1) > XW'(n_r)) ? n_r : IW'(lm1);
    add_ok   = (left_r != '0) && (XW'(left_r) <= XW'(n_r));
    low      = idx_r & (~idx_r + 1'b1);
    cand     = pos_r + step_r;
    sel_next = cur_r + rdata_r;
    sel_ge   = $signed(sel_next) >= $signed(target_r);
    diff     = hi_r - acc_r;
  end

  assign clr_busy = (clr_cnt_r != (AW+1)'(TABLE_SIZE));
  assign clr_done = !clr_busy;

  always_comb begin
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    cur_nxt  = cur_r;
    pos_nxt  = pos_r;
    step_nxt = step_r;
    cand_nxt = cand_r;
    wadr_nxt = wadr_r;
    pend_nxt = 1'b0;
    rd_en    = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = wadr_r;
    wdata    = rdata_r + amount_r;
    case (cw.op)
      OP_LOAD_P: begin
        idx_nxt = left_cl;
        acc_nxt = '0;
      end
      OP_LOAD_R: begin
        idx_nxt = right_cl;
        acc_nxt = '0;
      end
      OP_SAVE_LO: begin
        hi_nxt  = acc_r;
        idx_nxt = lm1_cl;
        acc_nxt = '0;
      end
      OP_PWALK: begin
        // read of this cycle lands next cycle, summed behind the walk
        if (pend_r) begin
          acc_nxt = acc_r + rdata_r;
        end
        if (idx_r != '0) begin
          rd_en    = 1'b1;
          raddr    = AW'(idx_r - 1'b1);
          idx_nxt  = idx_r - low;
          pend_nxt = 1'b1;
        end
      end
      OP_LOAD_ADD: begin
        idx_nxt = add_ok ? IW'(left_r) : '0;
      end
      OP_AWALK: begin
        // write back the previous cell while reading the next one
        if (pend_r) begin
          we = 1'b1;
        end
        if (stat.add_more) begin
          rd_en    = 1'b1;
          raddr    = AW'(idx_r - 1'b1);
          wadr_nxt = AW'(idx_r - 1'b1);
          idx_nxt  = idx_r + low;
          pend_nxt = 1'b1;
        end
      end
      OP_SINIT: begin
        pos_nxt  = '0;
        cur_nxt  = '0;
        step_nxt = IW'(STEP_TOP);
      end
      OP_SREAD: begin
        cand_nxt = cand;
        if (cand < n_r) begin
          rd_en    = 1'b1;
          raddr    = AW'(cand - 1'b1);
          pend_nxt = 1'b1;
        end
      end
      OP_SEVAL: begin
        if (pend_r && !sel_ge) begin
          pos_nxt = cand_r;
          cur_nxt = sel_next;
        end
        step_nxt = step_r >> 1;
      end
      default: begin
      end
    endcase
    if (clr_busy) begin
      we    = 1'b1;
      waddr = clr_cnt_r[AW-1:0];
      wdata = '0;
    end
  end

  always_comb begin
    stat.idx_nz    = (idx_r != '0);
    stat.add_more  = (idx_r != '0) && (idx_r <= n_r);
    stat.step_more = ((step_r >> 1) != '0);
  end

  always_comb begin
    res_total = '0;
    res_found = '0;
    case (cw.op)
      OP_EMIT_SUM:   res_total = OUT_W'(acc_r);
      OP_EMIT_RANGE: res_total = OUT_W'(diff);
      OP_EMIT_SEL:   res_found = IDX_W'(pos_r + 1'b1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (clr_busy) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      left_r   <= left_index;
      right_r  <= right_index;
      amount_r <= VW'(amount);
      target_r <= VW'(rank_target);
      n_r      <= n_start;
    end
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    hi_r   <= hi_nxt;
    cur_r  <= cur_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    cand_r <= cand_nxt;
    wadr_r <= wadr_nxt;
  end

endmodule

// ----- hw/rtl/fenwick_tree_engine_unit.sv -----
// ----------------------------------------------------------------------------
// fenwick_tree_engine_unit
// Binary indexed tree over TABLE_SIZE signed counters of VALUE_WIDTH bits.
// Four operations per input transaction: point add (no result), prefix sum,
// range sum and select by rank (one result each). Sums wrap in two's
// complement; query positions above the size in use are clamped to it and
// adds at position zero or above the size are dropped. One item is worked
// at a time by a small microprogram that walks the tree through a single
// memory with one read and one write port; select reads and then tests
// one candidate position per halving step. After reset the cells are
// cleared one per cycle; no input transaction is taken during that pass,
// configuration writes are. A finished result sits in an output register,
// so the engine goes back to idle and takes the next item while the
// result waits.
// ----------------------------------------------------------------------------
module fenwick_tree_engine_unit #(
  parameter int TABLE_SIZE  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // size register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fte_pkg::IDX_W-1:0] cfg_size_in_use,
  // operation transactions
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [fte_pkg::FUNC_W-1:0] in_func,
  input  logic [fte_pkg::IDX_W-1:0] in_left_index,
  input  logic [fte_pkg::IDX_W-1:0] in_right_index,
  input  logic signed [31:0]        in_amount,
  input  logic signed [31:0]        in_rank_target,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_total,
  output logic [fte_pkg::IDX_W-1:0] out_found_index
);
  import fte_pkg::*;

  logic [IDX_W-1:0] size_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_total_r;
  logic [IDX_W-1:0] out_found_r;

  ucode_t           cw;
  dp_stat_t         stat;
  logic             seq_busy;
  logic             emit_fire;
  logic             clr_done;
  logic             accept;
  logic             out_block;
  logic [OUT_W-1:0] res_total;
  logic [IDX_W-1:0] res_found;

  // configuration is always taken; the user must only change it while the engine idles, the block does not enforce this
  assign cfg_ready = 1'b1;

  // new items wait for the clearing pass and for the current item
  assign in_ready  = clr_done && !seq_busy;
  assign accept    = in_valid && in_ready;

  // result slot holds until the consumer takes it
  assign out_block = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_size_in_use;
    end
  end

  fte_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .func      (func_t'(in_func)),
    .stat      (stat),
    .out_block (out_block),
    .cw        (cw),
    .emit_fire (emit_fire),
    .busy      (seq_busy)
  );

  fte_dpath #(
    .TABLE_SIZE  (TABLE_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .size_in_use (size_r),
    .left_index  (in_left_index),
    .right_index (in_right_index),
    .amount      (in_amount),
    .rank_target (in_rank_target),
    .cw          (cw),
    .stat        (stat),
    .clr_done    (clr_done),
    .res_total   (res_total),
    .res_found   (res_found)
  );

  // output register: loaded by an emit step, freed by the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_total_r <= res_total;
      out_found_r <= res_found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total       = signed'(out_total_r);
  assign out_found_index = out_found_r;

  // no item may start before the cells are cleared
  a_accept_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> clr_done)
    else $error("item taken during clearing pass");

  // a result never lands on an untaken one
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // an accepted item always runs the program
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> seq_busy)
    else $error("sequencer did not start on accepted item");

  // results only come from a running program
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_busy |-> !emit_fire)
    else $error("result emitted while idle");

endmodule

// ----- tb/fte_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fte_tb_pkg
// Shadow copy of the fenwick tree with its size register. It works out the
// answer of every accepted operation and checks result transactions in order.
// ----------------------------------------------------------------------------
package fte_tb_pkg;

  import fte_pkg::*;

  localparam int CELLS = 1024;

  typedef struct packed {
    logic signed [31:0] total;
    logic [IDX_W-1:0]   found_index;
  } answer_t;

  class fenwick_shadow;
    logic [31:0]      cells [0:CELLS];
    logic [IDX_W-1:0] size_reg;
    answer_t          pending_answers [$];
    int unsigned      errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      size_reg = SIZE_RESET;
      errors   = 0;
    endfunction

    function void write_size(logic [IDX_W-1:0] v);
      size_reg = v;
    endfunction

    // walk bound: zero acts as one, oversize acts as the table size
    function int unsigned bound();
      if (size_reg == '0) return 1;
      if (size_reg > CELLS) return CELLS;
      return size_reg;
    endfunction

    function logic [31:0] prefix_of(int unsigned p);
      logic [31:0] acc;
      int unsigned i;
      int unsigned n;
      n   = bound();
      acc = '0;
      i   = (p > n) ? n : p;
      while (i > 0) begin
        acc = acc + cells[i];
        i   = i - (i & (~i + 1));
      end
      return acc;
    endfunction

    function logic [IDX_W-1:0] select_rank(logic signed [31:0] target);
      int unsigned        pos;
      int unsigned        step;
      int unsigned        cand;
      int unsigned        n;
      logic signed [31:0] cur;
      logic signed [31:0] nxt;
      n    = bound();
      pos  = 0;
      step = 1;
      cur  = '0;
      while ((step << 1) <= n) step = step << 1;
      while (step > 0) begin
        cand = pos + step;
        if (cand < n) begin
          nxt = cur + cells[cand];
          if (!(nxt >= target)) begin
            pos = cand;
            cur = nxt;
          end
        end
        step = step >> 1;
      end
      return IDX_W'(pos + 1);
    endfunction

    function void note_op(func_t f, logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                          logic signed [31:0] amt, logic signed [31:0] tgt);
      answer_t     a;
      int unsigned i;
      int unsigned n;
      n = bound();
      a = '0;
      case (f)
        FUNC_ADD: begin
          i = l;
          if (i != 0 && i <= n) begin
            while (i <= n) begin
              cells[i] = cells[i] + amt;
              i = i + (i & (~i + 1));
            end
          end
          return;
        end
        FUNC_PREFIX: a.total = prefix_of(l);
        FUNC_RANGE: a.total = prefix_of(r) - ((l == '0) ? 32'd0 : prefix_of(l - 1));
        FUNC_SELECT: a.found_index = select_rank(tgt);
        default: a = '0;
      endcase
      pending_answers.push_back(a);
    endfunction

    function void check_answer(logic signed [31:0] total, logic [IDX_W-1:0] found);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("result with nothing pending: total %0d found_index %0d", total, found);
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      if (total !== a.total) begin
        $error("total: expected %0d, actual %0d", a.total, total);
        errors++;
      end
      if (found !== a.found_index) begin
        $error("found_index: expected %0d, actual %0d", a.found_index, found);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression of the fenwick tree engine: directed corner cases, then random
// operation mixes over several size settings, with random idling on both
// channels in most of them, checked against a shadow tree.
// ----------------------------------------------------------------------------
module tb_top;

  import fte_pkg::*;
  import fte_tb_pkg::*;

  localparam int TAIL_CYCLES = 40;     // engine drain margin after the last result
  localparam int PHASE_ITEMS = 115;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_size_in_use;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [IDX_W-1:0]    in_left_index;
  logic [IDX_W-1:0]    in_right_index;
  logic signed [31:0]  in_amount;
  logic signed [31:0]  in_rank_target;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  out_total;
  logic [IDX_W-1:0]    out_found_index;

  fenwick_shadow shadow;
  bit            idle_on;              // random gaps and stalls enabled

  fenwick_tree_engine_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_size_in_use (cfg_size_in_use),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_amount       (in_amount),
    .in_rank_target  (in_rank_target),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_total       (out_total),
    .out_found_index (out_found_index)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop for a hung engine
  initial begin
    #5_000_000;
    $display("fenwick_tree_engine_unit regression: fail");
    $finish;
  end

  // wait for all results, then let a trailing add walk finish
  task automatic wait_drained();
    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // size register write, only with the engine idle
  task automatic write_size(logic [IDX_W-1:0] v);
    wait_drained();
    cfg_valid       <= 1'b1;
    cfg_size_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.write_size(v);
    cfg_valid <= 1'b0;
  endtask

  // one operation transaction; valid stays up when no gap follows
  task automatic send_op(func_t f, logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                         logic signed [31:0] amt, logic signed [31:0] tgt);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_left_index  <= l;
    in_right_index <= r;
    in_amount      <= amt;
    in_rank_target <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_op(f, l, r, amt, tgt);
  endtask

  // mostly in-range positions, with zero, the bound, just past it and wild
  function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return IDX_W'($urandom_range(1, n));
    if (p < 86) return '0;
    if (p < 90) return IDX_W'(n);
    if (p < 94) return IDX_W'(n + 1);
    return IDX_W'($urandom_range(0, 2047));
  endfunction

  task automatic run_random(int unsigned count, bit hold_mid);
    int unsigned        n;
    int unsigned        pick;
    logic [31:0]        total_now;
    func_t              f;
    logic [IDX_W-1:0]   l;
    logic [IDX_W-1:0]   r;
    logic signed [31:0] amt;
    logic signed [31:0] tgt;
    for (int unsigned k = 0; k < count; k++) begin
      n    = shadow.bound();
      pick = $urandom_range(0, 99);
      f    = (pick < 35) ? FUNC_ADD : (pick < 55) ? FUNC_PREFIX :
             (pick < 75) ? FUNC_RANGE : FUNC_SELECT;
      l    = pick_index(n);
      r    = pick_index(n);
      // mostly small non-negative counts so select has a sorted prefix
      pick = $urandom_range(0, 99);
      if (pick < 85) amt = $urandom_range(0, 40);
      else if (pick < 95) amt = 32'sd0 - $urandom_range(1, 40);
      else amt = $urandom;
      // targets mostly within the current grand total
      total_now = shadow.prefix_of(n);
      pick      = $urandom_range(0, 99);
      if (pick < 70 && !total_now[31]) tgt = $urandom_range(0, total_now + 1);
      else if (pick < 85) tgt = $urandom;
      else begin
        case ($urandom_range(0, 4))
          0:       tgt = 32'sd0;
          1:       tgt = -32'sd1;
          2:       tgt = 32'sd1;
          3:       tgt = 32'h8000_0000;
          default: tgt = 32'h7fff_ffff;
        endcase
      end
      // sender holds off until the engine has emptied out
      if (hold_mid && k == count / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      send_op(f, l, r, amt, tgt);
    end
  endtask

  // result side: random stall per transaction, ready kept high when none
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      shadow.check_answer(out_total, out_found_index);
    end
  end

  // main sequence
  initial begin
    logic [IDX_W-1:0] phase_sizes [10];
    logic [IDX_W-1:0] sz;
    shadow          = new();
    idle_on         = 1'b1;
    phase_sizes     = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd7,
                        11'd1000, 11'd513, 11'd16, 11'd0, 11'd1024};
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_size_in_use <= '0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_ADD;
    in_left_index   <= '0;
    in_right_index  <= '0;
    in_amount       <= '0;
    in_rank_target  <= '0;
    out_ready       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size written during the clearing pass
    write_size(11'd1024);

    // directed corners at full size
    send_op(FUNC_ADD,    11'd0,    11'd0,    32'sd5,        32'sd0);  // position zero dropped
    send_op(FUNC_ADD,    11'd1,    11'd0,    32'h7fff_ffff, 32'sd0);
    send_op(FUNC_ADD,    11'd1024, 11'd0,    32'h8000_0000, 32'sd0);
    send_op(FUNC_ADD,    11'd1025, 11'd0,    32'sd9,        32'sd0);  // above size, dropped
    send_op(FUNC_ADD,    11'd2047, 11'd2047, 32'sd3,        32'sd0);
    send_op(FUNC_ADD,    11'd512,  11'd0,    32'sd10,       32'sd0);
    send_op(FUNC_ADD,    11'd3,    11'd0,    -32'sd1,       32'sd0);
    send_op(FUNC_PREFIX, 11'd0,    11'd0,    32'sd0,        32'sd0);
    send_op(FUNC_PREFIX, 11'd1,    11'd0,    32'sd0,        32'sd0);
    send_op(FUNC_PREFIX, 11'd1024, 11'd0,    32'sd0,        32'sd0);
    send_op(FUNC_PREFIX, 11'd2047, 11'd0,    32'sd0,        32'sd0);  // clamped
    send_op(FUNC_RANGE,  11'd0,    11'd1024, 32'sd0,        32'sd0);  // empty lower prefix
    send_op(FUNC_RANGE,  11'd2,    11'd600,  32'sd0,        32'sd0);
    send_op(FUNC_RANGE,  11'd600,  11'd2,    32'sd0,        32'sd0);  // reversed ends
    send_op(FUNC_RANGE,  11'd1025, 11'd2047, 32'sd0,        32'sd0);  // both ends clamped
    send_op(FUNC_RANGE,  11'd1,    11'd1,    32'sd0,        32'sd0);
    send_op(FUNC_SELECT, 11'd0,    11'd0,    32'sd0,        32'sd0);  // zero target
    send_op(FUNC_SELECT, 11'd0,    11'd0,    32'sd0,        32'h8000_0000);
    send_op(FUNC_SELECT, 11'd0,    11'd0,    32'sd0,        32'h7fff_ffff); // never reached
    send_op(FUNC_SELECT, 11'd0,    11'd0,    32'sd0,        32'sd1);
    send_op(FUNC_SELECT, 11'd0,    11'd0,    32'sd0,        32'sd10);
    send_op(FUNC_ADD,    11'd1,    11'd0,    32'h8000_0001, 32'sd0);  // forces wrap
    send_op(FUNC_PREFIX, 11'd1024, 11'd0,    32'sd0,        32'sd0);
    in_valid <= 1'b0;

    // random phases over several sizes, some without any idling
    for (int ph = 0; ph < 10; ph++) begin
      sz = (ph == 8) ? IDX_W'($urandom_range(3, 1023)) : phase_sizes[ph];
      write_size(sz);
      idle_on = (ph % 3 != 2);
      run_random(PHASE_ITEMS, ph == 5);
      in_valid <= 1'b0;
    end

    wait_drained();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("fenwick_tree_engine_unit regression: pass");
    end else begin
      $display("fenwick_tree_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fte_pkg.sv
hw/rtl/fte_useq.sv
hw/rtl/fte_dpath.sv
hw/rtl/fenwick_tree_engine_unit.sv
tb/fte_tb_pkg.sv
tb/tb_top.sv
